// ----- rtl/frwl_pkg.sv -----
// Shared types and constants of the fair reader-writer lock arbiter.
// Used by the wait queue, the top level, the checker and the testbench. No dependencies.
package frwl_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  // Reader count is a fixed 8-bit field that saturates at its maximum.
  localparam int          RC_W       = 8;
  localparam logic [7:0] READER_MAX = 8'd255;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_UNLOCK    = 2'd2,
    OP_DOWNGRADE = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_GRANT    = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_WOKEN    = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_t;

  // Wait queue control: shift pops the head, load writes at the fill index.
  typedef struct packed {
    logic shift;
    logic load;
  } queue_ctrl_t;

endpackage

// ----- rtl/frwl_cell.sv -----
// One wait-queue cell: holds a waiting thread id and its writer flag.
// Takes its neighbor's entry on a shift, or a new entry on a write. No dependencies.
module frwl_cell #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         wr,
  input  logic [W-1:0] shift_in,
  input  logic [W-1:0] wr_in,
  output logic [W-1:0] data_out
);

  logic [W-1:0] data_r;

  // A shift moves the queue toward the head; a write fills the first free cell.
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= shift_in;
    end else if (wr) begin
      data_r <= wr_in;
    end
  end

  assign data_out = data_r;

endmodule

// ----- rtl/frwl_queue.sv -----
// Wait queue of the lock arbiter: a chain of frwl_cell instances, head in cell 0.
// Depends on frwl_pkg (queue_ctrl_t) and frwl_cell.
module frwl_queue
  import frwl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int W     = THREAD_ID_BITS_DEF + 1,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  queue_ctrl_t      ctrl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [W-1:0]     wr_data,
  output logic [W-1:0]     head_data,
  output logic [W-1:0]     next_data
);

  logic [W-1:0] cell_q [DEPTH];

  // Each cell takes the entry of the cell behind it on a pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] from_behind;
    logic         wr_sel;

    if (i < DEPTH - 1) begin : g_mid
      assign from_behind = cell_q[i+1];
    end else begin : g_end
      assign from_behind = cell_q[i];
    end

    assign wr_sel = ctrl.load && (wr_idx == IDX_W'(i));

    frwl_cell #(.W(W)) u_cell (
      .clk      (clk),
      .shift    (ctrl.shift),
      .wr       (wr_sel),
      .shift_in (from_behind),
      .wr_in    (wr_data),
      .data_out (cell_q[i])
    );
  end

  assign head_data = cell_q[0];
  assign next_data = cell_q[1];

endmodule

// ----- rtl/fair_reader_writer_lock_arbiter.sv -----
// Fair reader-writer lock arbiter: top level with the request sequencer and result register.
// Depends on frwl_pkg and frwl_queue.
//
// Requests arrive on the in_ channel (operation in in_tuser, thread id in in_tdata) and
// each gives one or more results on the out_ channel, the final one marked by out_tlast.
// Waiting threads sit in a FIFO built as a chain of cells; a pop shifts every cell one
// place toward the head, so a wake run produces one result per cycle while the out_ side
// takes them. A request is captured on acceptance and decided in S_EXEC once the output
// register is free, which loads its first result; further woken readers follow from
// S_WAKE, and the sequencer stalls while a result waits with tready held low.
// The next request is accepted in the cycle after the final result is loaded into the
// output register, while that result may still be waiting to be taken. There is no
// clearing pass after reset: queue contents are tracked by a fill count.
module fair_reader_writer_lock_arbiter
  import frwl_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  localparam int IN_TDATA_W  = ((THREAD_ID_BITS + 7) / 8) * 8,
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_BITS    = THREAD_ID_BITS + RC_W + 1 + FILL_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // thread_id, zero padded
  input  logic [1:0]             in_tuser,   // op
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // granted_thread, readers_holding,
                                             // writer_holding, waiting_count, zero padded
  output logic [2:0]             out_tuser,  // kind
  output logic                   out_tlast
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QW    = THREAD_ID_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  state_t                    state_r, state_nxt;
  op_t                       op_r;
  logic [THREAD_ID_BITS-1:0] tid_r;
  logic [RC_W-1:0]           rc_r, rc_nxt;
  logic                      writer_r, writer_nxt;
  logic [THREAD_ID_BITS-1:0] owner_r, owner_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;

  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic [2:0]                out_kind_r;
  logic                      out_last_r;

  logic                      emit;
  kind_t                     kind;
  logic [THREAD_ID_BITS-1:0] res_tid;
  logic                      res_last;
  logic                      slot_free;
  logic                      q_full;
  logic                      do_enq;
  logic                      enq_writer;

  queue_ctrl_t               qctrl;
  logic [QW-1:0]             head_data, next_data;
  logic                      head_w, next_w;
  logic [THREAD_ID_BITS-1:0] head_tid;

  frwl_queue #(.DEPTH(QUEUE_DEPTH), .W(QW)) u_queue (
    .clk       (clk),
    .ctrl      (qctrl),
    .wr_idx    (fill_r[IDX_W-1:0]),
    .wr_data   ({enq_writer, tid_r}),
    .head_data (head_data),
    .next_data (next_data)
  );

  assign head_w    = head_data[QW-1];
  assign head_tid  = head_data[THREAD_ID_BITS-1:0];
  assign next_w    = next_data[QW-1];
  assign slot_free = !out_valid_r || out_tready;
  assign q_full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign in_tready = (state_r == S_IDLE);

  // Decide the next result and the lock state it leaves behind.
  always_comb begin
    state_nxt  = state_r;
    rc_nxt     = rc_r;
    writer_nxt = writer_r;
    owner_nxt  = owner_r;
    fill_nxt   = fill_r;
    emit       = 1'b0;
    kind       = KIND_ERROR;
    res_tid    = tid_r;
    res_last   = 1'b1;
    qctrl      = '0;
    do_enq     = 1'b0;
    enq_writer = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          emit = 1'b1;
          case (op_r)
            OP_READ: begin
              if (writer_r || fill_r != '0) begin
                do_enq = 1'b1;
              end else if (rc_r != READER_MAX) begin
                rc_nxt = rc_r + 1'b1;
                kind   = KIND_GRANT;
              end
            end
            OP_WRITE: begin
              enq_writer = 1'b1;
              if (writer_r || rc_r != '0 || fill_r != '0) begin
                do_enq = 1'b1;
              end else begin
                writer_nxt = 1'b1;
                owner_nxt  = tid_r;
                kind       = KIND_GRANT;
              end
            end
            OP_UNLOCK: begin
              if (!writer_r && rc_r > RC_W'(1)) begin
                // Other readers still hold the lock.
                rc_nxt = rc_r - 1'b1;
                kind   = KIND_RELEASED;
              end else if (writer_r || rc_r != '0) begin
                // Holders drop to zero: hand the lock to the head of the queue.
                writer_nxt = 1'b0;
                rc_nxt     = '0;
                if (fill_r == '0) begin
                  kind = KIND_RELEASED;
                end else if (head_w) begin
                  qctrl.shift = 1'b1;
                  fill_nxt    = fill_r - 1'b1;
                  writer_nxt  = 1'b1;
                  owner_nxt   = head_tid;
                  kind        = KIND_WOKEN;
                  res_tid     = head_tid;
                end else begin
                  qctrl.shift = 1'b1;
                  fill_nxt    = fill_r - 1'b1;
                  rc_nxt      = RC_W'(1);
                  kind        = KIND_WOKEN;
                  res_tid     = head_tid;
                  res_last    = !(fill_r > FILL_W'(1) && !next_w);
                end
              end
            end
            OP_DOWNGRADE: begin
              if (writer_r && owner_r == tid_r) begin
                writer_nxt = 1'b0;
                rc_nxt     = RC_W'(1);
                kind       = KIND_GRANT;
                res_last   = !(fill_r != '0 && !head_w);
              end
            end
            default: begin
              kind = KIND_ERROR;
            end
          endcase

          // Queue the requester, or flag a full queue.
          if (do_enq && !q_full) begin
            qctrl.load = 1'b1;
            fill_nxt   = fill_r + 1'b1;
            kind       = KIND_QUEUED;
          end

          state_nxt = res_last ? S_IDLE : S_WAKE;
        end
      end

      S_WAKE: begin
        // Wake one leading reader per cycle while the output register is free.
        if (slot_free) begin
          emit        = 1'b1;
          qctrl.shift = 1'b1;
          fill_nxt    = fill_r - 1'b1;
          rc_nxt      = rc_r + 1'b1;
          kind        = KIND_WOKEN;
          res_tid     = head_tid;
          res_last    = !(fill_r > FILL_W'(1) && !next_w && rc_nxt != READER_MAX);
          state_nxt   = res_last ? S_IDLE : S_WAKE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, lock state and the result register.
  // The result payload is not reset; out_tvalid qualifies it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rc_r        <= '0;
      writer_r    <= 1'b0;
      owner_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rc_r     <= rc_nxt;
      writer_r <= writer_nxt;
      owner_r  <= owner_nxt;
      fill_r   <= fill_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= OUT_TDATA_W'({fill_nxt, writer_nxt, rc_nxt, res_tid});
        out_kind_r  <= kind;
        out_last_r  <= res_last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= op_t'(in_tuser);
      tid_r <= in_tdata[THREAD_ID_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sim/frwl_lock_checker.sv -----
// Result checker for the fair reader-writer lock arbiter: watches both streams,
// predicts the results of every accepted request and compares them in order.
// Depends on frwl_pkg for the operation codes, result kinds and default sizes.
module frwl_lock_checker
  import frwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // thread_id
  input  logic [1:0]  in_tuser,   // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // granted_thread, readers_holding, writer_holding,
                                  // waiting_count, zero padded
  input  logic [2:0]  out_tuser,  // kind
  input  logic        out_tlast,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] thread;
    logic [7:0] readers;
    logic       writer;
    logic [4:0] waiting;
    logic       last;
  } lock_result_t;

  typedef struct packed {
    logic [7:0] thread;
    logic       is_writer;
  } waiter_t;

  // Predicted lock state.
  int unsigned  held_readers;
  bit           writer_owns;
  logic [7:0]   owner_id;
  waiter_t      waiters[$];

  // Results predicted but not yet seen on the out_ stream.
  lock_result_t results_due[$];

  initial begin
    held_readers = 0;
    writer_owns  = 1'b0;
    owner_id     = '0;
  end

  // Queue one predicted result that shows the lock state as it stands now.
  function automatic void note_result(kind_t kind, logic [7:0] thread);
    lock_result_t r;
    r.kind    = kind;
    r.thread  = thread;
    r.readers = held_readers[7:0];
    r.writer  = writer_owns;
    r.waiting = 5'(waiters.size());
    r.last    = 1'b0;
    results_due.push_back(r);
  endfunction

  // Wake the run of readers at the head of the wait list; a writer ends the run.
  function automatic void wake_reader_run();
    logic [7:0] t;
    while (waiters.size() != 0 && !waiters[0].is_writer && held_readers < READER_MAX) begin
      t = waiters[0].thread;
      void'(waiters.pop_front());
      held_readers++;
      note_result(KIND_WOKEN, t);
    end
  endfunction

  // Nobody holds the lock any more: hand it to the head writer or the leading readers.
  function automatic void hand_on_lock(logic [7:0] requester);
    waiter_t head;
    if (waiters.size() == 0) begin
      note_result(KIND_RELEASED, requester);
    end else if (waiters[0].is_writer) begin
      head = waiters.pop_front();
      writer_owns = 1'b1;
      owner_id    = head.thread;
      note_result(KIND_WOKEN, head.thread);
    end else begin
      wake_reader_run();
    end
  endfunction

  function automatic void park_request(logic [7:0] requester, logic is_writer);
    waiter_t w;
    if (waiters.size() >= QUEUE_DEPTH_DEF) begin
      note_result(KIND_ERROR, requester);
    end else begin
      w.thread    = requester;
      w.is_writer = is_writer;
      waiters.push_back(w);
      note_result(KIND_QUEUED, requester);
    end
  endfunction

  // Work out every result of one accepted request and mark the final one.
  function automatic void apply_lock_request(op_t op, logic [7:0] requester);
    lock_result_t tail;
    case (op)
      OP_READ: begin
        if (writer_owns || waiters.size() != 0) begin
          park_request(requester, 1'b0);
        end else if (held_readers >= READER_MAX) begin
          note_result(KIND_ERROR, requester);
        end else begin
          held_readers++;
          note_result(KIND_GRANT, requester);
        end
      end
      OP_WRITE: begin
        if (writer_owns || held_readers != 0 || waiters.size() != 0) begin
          park_request(requester, 1'b1);
        end else begin
          writer_owns = 1'b1;
          owner_id    = requester;
          note_result(KIND_GRANT, requester);
        end
      end
      OP_UNLOCK: begin
        if (writer_owns) begin
          writer_owns = 1'b0;
          hand_on_lock(requester);
        end else if (held_readers != 0) begin
          held_readers--;
          if (held_readers != 0) note_result(KIND_RELEASED, requester);
          else hand_on_lock(requester);
        end else begin
          note_result(KIND_ERROR, requester);
        end
      end
      default: begin
        if (!writer_owns || owner_id != requester) begin
          note_result(KIND_ERROR, requester);
        end else begin
          writer_owns  = 1'b0;
          held_readers = 1;
          note_result(KIND_GRANT, requester);
          wake_reader_run();
        end
      end
    endcase
    tail = results_due.pop_back();
    tail.last = 1'b1;
    results_due.push_back(tail);
  endfunction

  // Compare one taken result with the oldest prediction.
  function automatic void check_result();
    lock_result_t got;
    lock_result_t want;
    got.kind    = kind_t'(out_tuser);
    got.thread  = out_tdata[7:0];
    got.readers = out_tdata[15:8];
    got.writer  = out_tdata[16];
    got.waiting = out_tdata[21:17];
    got.last    = out_tlast;
    if (results_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: unpredicted result kind %0d thread %0d readers %0d %s",
                 got.kind, got.thread, got.readers,
                 $sformatf("writer %0d wait %0d last %0d",
                           got.writer, got.waiting, got.last));
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.thread !== want.thread ||
          got.readers !== want.readers || got.writer !== want.writer ||
          got.waiting !== want.waiting || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected kind %0d thread %0d readers %0d writer %0d wait %0d last %0d",
                   want.kind, want.thread, want.readers, want.writer, want.waiting, want.last);
          $display("  actual   kind %0d thread %0d readers %0d writer %0d wait %0d last %0d",
                   got.kind, got.thread, got.readers, got.writer, got.waiting, got.last);
        end
      end
    end
  endfunction

  // A request is predicted in the cycle it is accepted, before any result it can cause.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_lock_request(op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) check_result();
    end
    pending = results_due.size();
  end

endmodule

// ----- sim/fair_reader_writer_lock_arbiter_tb.sv -----
// Testbench top for the fair reader-writer lock arbiter: clock, reset, request
// stimulus, result back-pressure and the final verdict.
// Depends on frwl_pkg, fair_reader_writer_lock_arbiter and frwl_lock_checker.
module fair_reader_writer_lock_arbiter_tb;
  import frwl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_READ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int          failures;
  int          pending;
  int          requests_sent  = 0;
  int          results_taken  = 0;
  int          cycle_count    = 0;
  logic        hold_ready     = 1'b0;
  logic [7:0]  last_writer_id = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fair_reader_writer_lock_arbiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  frwl_lock_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .failures  (failures),
    .pending   (pending)
  );

  // Result side: random stalls, a calm stretch with no stalls, and one long hold-off.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) results_taken <= results_taken + 1;
    if (hold_ready) begin
      out_tready <= 1'b0;
    end else if (results_taken >= 100 && results_taken < 180) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 11);
    end
  end

  // Long hold-off on the result side while requests keep coming, so the input stalls.
  initial begin
    wait (results_taken >= 80);
    @(posedge clk);
    hold_ready <= 1'b1;
    repeat (250) @(posedge clk);
    hold_ready <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fair_reader_writer_lock_arbiter test failed");
      $finish;
    end
  end

  // Offer one request and wait until it is accepted; valid stays high afterward.
  task automatic send_request(op_t op, logic [7:0] tid);
    while (!(requests_sent >= 100 && requests_sent < 180) && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tid;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (op == OP_WRITE) last_writer_id = tid;
  endtask

  function automatic logic [7:0] any_thread();
    return 8'($urandom_range(0, 255));
  endfunction

  // A downgrade usually comes from the most recent writer.
  function automatic logic [7:0] downgrade_thread();
    return ($urandom_range(0, 9) < 6) ? last_writer_id : any_thread();
  endfunction

  // Writer takes the lock, others pile up, then the writer lets go and the rest drain.
  task automatic writer_session();
    logic [7:0] w;
    int         crowd;
    w     = any_thread();
    crowd = $urandom_range(0, 6);
    send_request(OP_WRITE, w);
    repeat (crowd) send_request(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ, any_thread());
    if ($urandom_range(0, 1) == 1) send_request(OP_DOWNGRADE, w);
    else send_request(OP_UNLOCK, any_thread());
    repeat (crowd + 2) send_request(OP_UNLOCK, any_thread());
  endtask

  // Many readers share the lock, with a few writers caught in between.
  task automatic reader_session();
    int crowd;
    crowd = $urandom_range(2, 8);
    repeat (crowd) send_request(($urandom_range(0, 4) == 0) ? OP_WRITE : OP_READ, any_thread());
    repeat (crowd + 1) send_request(OP_UNLOCK, any_thread());
  endtask

  task automatic noise_burst();
    op_t op;
    repeat ($urandom_range(3, 10)) begin
      op = op_t'($urandom_range(0, 3));
      send_request(op, (op == OP_DOWNGRADE) ? downgrade_thread() : any_thread());
    end
  endtask

  initial begin
    int  random_start;
    int  pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors on an idle lock, sharing, queuing, wake runs, downgrade.
    send_request(OP_UNLOCK, 8'h00);     // release with nothing held
    send_request(OP_DOWNGRADE, 8'h00);  // downgrade with no writer
    send_request(OP_READ, 8'h00);
    send_request(OP_READ, 8'hFF);
    send_request(OP_WRITE, 8'hAA);      // readers hold, so the writer waits
    send_request(OP_READ, 8'h55);       // queue not empty, so the reader waits
    send_request(OP_READ, 8'h01);
    send_request(OP_WRITE, 8'h02);
    send_request(OP_READ, 8'h03);
    send_request(OP_UNLOCK, 8'h00);     // one reader still holds
    send_request(OP_UNLOCK, 8'hFF);     // last reader out wakes the head writer
    send_request(OP_READ, 8'h80);
    send_request(OP_DOWNGRADE, 8'h11);  // not the owner
    send_request(OP_DOWNGRADE, 8'hAA);  // wakes readers up to the queued writer
    send_request(OP_UNLOCK, 8'hAA);
    send_request(OP_UNLOCK, 8'h55);
    send_request(OP_UNLOCK, 8'h01);     // wakes writer 0x02
    send_request(OP_WRITE, 8'h7F);
    send_request(OP_UNLOCK, 8'h33);     // any thread may release a writer
    send_request(OP_UNLOCK, 8'h03);
    send_request(OP_UNLOCK, 8'h80);     // wakes writer 0x7F
    send_request(OP_UNLOCK, 8'h7F);     // writer out, nobody waiting
    send_request(OP_WRITE, 8'h00);
    send_request(OP_UNLOCK, 8'h00);

    // Full wait queue behind a writer, then drain with a few surplus unlocks.
    send_request(OP_WRITE, 8'hE7);
    repeat (17) send_request(($urandom_range(0, 2) == 0) ? OP_WRITE : OP_READ, any_thread());
    repeat (20) send_request(OP_UNLOCK, any_thread());

    // Random sessions, mostly well-formed.
    random_start = requests_sent;
    while (requests_sent - random_start < 188) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) writer_session();
      else if (pick < 8) reader_session();
      else noise_burst();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("fair_reader_writer_lock_arbiter test passed");
    end else begin
      $display("fair_reader_writer_lock_arbiter test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/frwl_pkg.sv
rtl/frwl_cell.sv
rtl/frwl_queue.sv
rtl/fair_reader_writer_lock_arbiter.sv
sim/frwl_lock_checker.sv
sim/fair_reader_writer_lock_arbiter_tb.sv
